>>> hdl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Shared widths, codes, types and the gradient function of the noise sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CELL_W    = 8;
    localparam int POS_W     = 32;
    localparam int EXT_W     = POS_W + 1;
    localparam int OFS_W     = 24;
    localparam int AMP_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam int FADE_W  = FRAC_BITS + 1;
    localparam int CRD_W   = FRAC_BITS + 2;
    localparam int GRAD_W  = FRAC_BITS + 3;
    localparam int LERP_W  = FRAC_BITS + 4;
    localparam int INNER_W = FRAC_BITS + 4;
    localparam int POLY_W  = FRAC_BITS + 8;
    localparam int DIFF_W  = FRAC_BITS + 5;
    localparam int MA_W    = 32;
    localparam int MB_W    = DIFF_W;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SUM_W   = PROD_W - FRAC_BITS + 1;

    localparam logic [AMP_W-1:0]         AMP_RESET = AMP_W'(65536);
    localparam logic [POLY_W-1:0]        TEN_ONE   = POLY_W'(10 * (1 << FRAC_BITS));
    localparam logic signed [CRD_W-1:0]  ONE_CRD   = CRD_W'(1 << FRAC_BITS);
    localparam logic signed [POS_W-1:0]  S32_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  S32_MIN   = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_SAMPLE      = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X  = 2'd0,
        CFG_OFFSET_Y  = 2'd1,
        CFG_OFFSET_Z  = 2'd2,
        CFG_AMPLITUDE = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FADE_SQ,
        S_FADE_CUBE,
        S_FADE_POLY,
        S_FADE_STORE,
        S_HASH_X0,
        S_HASH_X1,
        S_HASH_A0,
        S_HASH_A1,
        S_HASH_B0,
        S_HASH_B1,
        S_HASH_LAST,
        S_CORNER_RD,
        S_CORNER_GRAD,
        S_CORNER_LERP,
        S_Y0_MUL,
        S_Y0_ADD,
        S_Y1_MUL,
        S_Y1_ADD,
        S_Z_MUL,
        S_Z_ADD,
        S_AMP_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [CELL_W-1:0]       ix;
        logic [CELL_W-1:0]       iy;
        logic [CELL_W-1:0]       iz;
        logic [FRAC_BITS-1:0]    dx;
        logic [FRAC_BITS-1:0]    dy;
        logic [FRAC_BITS-1:0]    dz;
        logic                    planar;
        logic                    column_start;
        logic signed [POS_W-1:0] acc;
    } sample_t;

    // improved gradient on the low four hash bits
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0]              h,
        input logic signed [CRD_W-1:0] x,
        input logic signed [CRD_W-1:0] y,
        input logic signed [CRD_W-1:0] z
    );
        logic signed [GRAD_W-1:0] u;
        logic signed [GRAD_W-1:0] v;
        u = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        if (h < 4'd4)
            v = GRAD_W'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = GRAD_W'(x);
        else
            v = GRAD_W'(z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

`default_nettype wire

>>> hdl/pns_perm_ram.sv
// ----------------------------------------------------------------------------
// pns_perm_ram
// Permutation table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_perm_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [pns_pkg::CELL_W-1:0] waddr,
    input  wire logic [pns_pkg::CELL_W-1:0] wdata,
    input  wire logic [pns_pkg::CELL_W-1:0] raddr,
    output logic      [pns_pkg::CELL_W-1:0] rdata
);

    logic [pns_pkg::CELL_W-1:0] mem [(1 << pns_pkg::CELL_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/pns_mul.sv
// ----------------------------------------------------------------------------
// pns_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_mul (
    input  wire logic                              clk,
    input  wire logic signed [pns_pkg::MA_W-1:0]   a,
    input  wire logic signed [pns_pkg::MB_W-1:0]   b,
    output logic signed      [pns_pkg::PROD_W-1:0] prod_reg
);

    logic signed [pns_pkg::PROD_W-1:0] prod_next;

    assign prod_next = pns_pkg::PROD_W'(a) * pns_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> hdl/pns_core.sv
// ----------------------------------------------------------------------------
// pns_core
// Sequencer and datapath: fades, corner hashing, lerps and final scaling,
// all products going through the one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire pns_pkg::sample_t             sample,
    input  wire logic [pns_pkg::AMP_W-1:0]    amplitude,
    input  wire logic                         out_free,
    input  wire logic [pns_pkg::CELL_W-1:0]   rd_data,
    output logic      [pns_pkg::CELL_W-1:0]   rd_addr,
    output logic                              idle,
    output logic                              done,
    output logic signed [pns_pkg::POS_W-1:0]  result
);

    localparam int F = pns_pkg::FRAC_BITS;

    pns_pkg::state_t state_reg, state_next;

    pns_pkg::sample_t smp_reg;
    logic             recompute_reg;
    logic [pns_pkg::CELL_W-1:0] last_y_reg;
    logic [1:0]       fsel_reg;
    logic [F-1:0]     t2_reg;
    logic [pns_pkg::FADE_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [pns_pkg::CELL_W-1:0] ha_reg, hb_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic [1:0]       pair_reg;
    logic             xbit_reg;
    logic signed [pns_pkg::GRAD_W-1:0] g0_reg;
    logic signed [pns_pkg::LERP_W-1:0] lx_reg    [4];
    logic signed [pns_pkg::LERP_W-1:0] cache_reg [4];
    logic signed [pns_pkg::LERP_W-1:0] y1_reg, y2_reg, n_reg;

    logic signed [pns_pkg::MA_W-1:0]   mul_a;
    logic signed [pns_pkg::MB_W-1:0]   mul_b;
    logic signed [pns_pkg::PROD_W-1:0] prod;

    logic [F-1:0]                  d_sel;
    logic [pns_pkg::FADE_W-1:0]    f_sel_val;
    logic [F-1:0]                  p_hi;
    logic [pns_pkg::POLY_W-1:0]    t2_w, d_w, inner_full;
    logic [pns_pkg::CELL_W-1:0]    iy_hash;
    logic [pns_pkg::CELL_W-1:0]    corner_base;
    logic signed [pns_pkg::CRD_W-1:0]  crd_x, crd_y, crd_z;
    logic signed [pns_pkg::GRAD_W-1:0] g_cur;
    logic signed [pns_pkg::LERP_W-1:0] ps;
    logic signed [pns_pkg::LERP_W-1:0] z_a, z_b;
    logic signed [pns_pkg::SUM_W-1:0]  sum;
    logic             last_pair;
    logic [1:0]       pair_step;

    pns_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // shared datapath terms
    always_comb
    begin
        unique case (fsel_reg)
            2'd0:    d_sel = smp_reg.dx;
            2'd1:    d_sel = smp_reg.dz;
            default: d_sel = smp_reg.dy;
        endcase
        f_sel_val  = prod[2*F:F];
        p_hi       = prod[2*F-1:F];
        t2_w       = pns_pkg::POLY_W'(t2_reg);
        d_w        = pns_pkg::POLY_W'(d_sel);
        inner_full = (t2_w << 2) + (t2_w << 1) + pns_pkg::TEN_ONE - (d_w << 4) + d_w;
        iy_hash    = smp_reg.planar ? '0 : smp_reg.iy;

        if (xbit_reg)
            corner_base = pair_reg[0] ? bb_reg : ba_reg;
        else
            corner_base = pair_reg[0] ? ab_reg : aa_reg;

        crd_x = $signed(pns_pkg::CRD_W'(smp_reg.dx)) - (xbit_reg ? pns_pkg::ONE_CRD : '0);
        crd_z = $signed(pns_pkg::CRD_W'(smp_reg.dz)) - (pair_reg[1] ? pns_pkg::ONE_CRD : '0);
        if (smp_reg.planar)
            crd_y = '0;
        else
            crd_y = $signed(pns_pkg::CRD_W'(smp_reg.dy))
                    - (pair_reg[0] ? pns_pkg::ONE_CRD : '0);
        g_cur = pns_pkg::grad(rd_data[3:0], crd_x, crd_y, crd_z);

        ps  = $signed(prod[F+pns_pkg::LERP_W-1:F]);
        z_a = smp_reg.planar ? lx_reg[0] : y1_reg;
        z_b = smp_reg.planar ? lx_reg[2] : y2_reg;

        sum = pns_pkg::SUM_W'($signed(smp_reg.acc))
              + pns_pkg::SUM_W'($signed(prod[pns_pkg::PROD_W-1:F]));

        // planar samples only visit the y-low corner pairs
        pair_step = smp_reg.planar ? 2'd2 : 2'd1;
        last_pair = smp_reg.planar ? (pair_reg == 2'd2) : (pair_reg == 2'd3);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pns_pkg::S_IDLE:       if (start) state_next = pns_pkg::S_FADE_SQ;
            pns_pkg::S_FADE_SQ:    state_next = pns_pkg::S_FADE_CUBE;
            pns_pkg::S_FADE_CUBE:  state_next = pns_pkg::S_FADE_POLY;
            pns_pkg::S_FADE_POLY:  state_next = pns_pkg::S_FADE_STORE;
            pns_pkg::S_FADE_STORE:
            begin
                if (fsel_reg != 2'd2)
                    state_next = pns_pkg::S_FADE_SQ;
                else if (smp_reg.planar || recompute_reg)
                    state_next = pns_pkg::S_HASH_X0;
                else
                    state_next = pns_pkg::S_Y0_MUL;
            end
            pns_pkg::S_HASH_X0:    state_next = pns_pkg::S_HASH_X1;
            pns_pkg::S_HASH_X1:    state_next = pns_pkg::S_HASH_A0;
            pns_pkg::S_HASH_A0:    state_next = pns_pkg::S_HASH_A1;
            pns_pkg::S_HASH_A1:    state_next = pns_pkg::S_HASH_B0;
            pns_pkg::S_HASH_B0:    state_next = pns_pkg::S_HASH_B1;
            pns_pkg::S_HASH_B1:    state_next = pns_pkg::S_HASH_LAST;
            pns_pkg::S_HASH_LAST:  state_next = pns_pkg::S_CORNER_RD;
            pns_pkg::S_CORNER_RD:  state_next = pns_pkg::S_CORNER_GRAD;
            pns_pkg::S_CORNER_GRAD:
                state_next = xbit_reg ? pns_pkg::S_CORNER_LERP : pns_pkg::S_CORNER_RD;
            pns_pkg::S_CORNER_LERP:
            begin
                if (!last_pair)
                    state_next = pns_pkg::S_CORNER_RD;
                else if (smp_reg.planar)
                    state_next = pns_pkg::S_Z_MUL;
                else
                    state_next = pns_pkg::S_Y0_MUL;
            end
            pns_pkg::S_Y0_MUL:     state_next = pns_pkg::S_Y0_ADD;
            pns_pkg::S_Y0_ADD:     state_next = pns_pkg::S_Y1_MUL;
            pns_pkg::S_Y1_MUL:     state_next = pns_pkg::S_Y1_ADD;
            pns_pkg::S_Y1_ADD:     state_next = pns_pkg::S_Z_MUL;
            pns_pkg::S_Z_MUL:      state_next = pns_pkg::S_Z_ADD;
            pns_pkg::S_Z_ADD:      state_next = pns_pkg::S_AMP_MUL;
            pns_pkg::S_AMP_MUL:    state_next = pns_pkg::S_OUT;
            pns_pkg::S_OUT:        if (out_free) state_next = pns_pkg::S_IDLE;
            default:               state_next = pns_pkg::S_IDLE;
        endcase
    end

    // outputs: table address, multiplier operands, result
    always_comb
    begin
        rd_addr = corner_base + pns_pkg::CELL_W'(pair_reg[1]);
        mul_a   = '0;
        mul_b   = '0;
        idle    = 1'b0;
        done    = 1'b0;
        if (sum > pns_pkg::SUM_W'(pns_pkg::S32_MAX))
            result = pns_pkg::S32_MAX;
        else if (sum < pns_pkg::SUM_W'(pns_pkg::S32_MIN))
            result = pns_pkg::S32_MIN;
        else
            result = sum[pns_pkg::POS_W-1:0];

        unique case (state_reg)
            pns_pkg::S_IDLE:      idle = 1'b1;
            pns_pkg::S_FADE_SQ:
            begin
                mul_a = pns_pkg::MA_W'(d_sel);
                mul_b = pns_pkg::MB_W'(d_sel);
            end
            pns_pkg::S_FADE_CUBE:
            begin
                mul_a = pns_pkg::MA_W'(p_hi);
                mul_b = pns_pkg::MB_W'(d_sel);
            end
            pns_pkg::S_FADE_POLY:
            begin
                mul_a = pns_pkg::MA_W'(p_hi);
                mul_b = pns_pkg::MB_W'(inner_full[pns_pkg::INNER_W-1:0]);
            end
            pns_pkg::S_HASH_X0:   rd_addr = smp_reg.ix;
            pns_pkg::S_HASH_X1:   rd_addr = smp_reg.ix + pns_pkg::CELL_W'(1);
            pns_pkg::S_HASH_A0:   rd_addr = ha_reg;
            pns_pkg::S_HASH_A1:   rd_addr = ha_reg + pns_pkg::CELL_W'(1);
            pns_pkg::S_HASH_B0:   rd_addr = hb_reg;
            pns_pkg::S_HASH_B1:   rd_addr = hb_reg + pns_pkg::CELL_W'(1);
            pns_pkg::S_CORNER_GRAD:
            begin
                mul_a = pns_pkg::MA_W'(fx_reg);
                mul_b = pns_pkg::MB_W'(g_cur) - pns_pkg::MB_W'(g0_reg);
            end
            pns_pkg::S_Y0_MUL:
            begin
                mul_a = pns_pkg::MA_W'(fy_reg);
                mul_b = pns_pkg::MB_W'(cache_reg[1]) - pns_pkg::MB_W'(cache_reg[0]);
            end
            pns_pkg::S_Y1_MUL:
            begin
                mul_a = pns_pkg::MA_W'(fy_reg);
                mul_b = pns_pkg::MB_W'(cache_reg[3]) - pns_pkg::MB_W'(cache_reg[2]);
            end
            pns_pkg::S_Z_MUL:
            begin
                mul_a = pns_pkg::MA_W'(fz_reg);
                mul_b = pns_pkg::MB_W'(z_b) - pns_pkg::MB_W'(z_a);
            end
            pns_pkg::S_AMP_MUL:
            begin
                mul_a = pns_pkg::MA_W'(amplitude);
                mul_b = pns_pkg::MB_W'(n_reg);
            end
            pns_pkg::S_OUT:
            begin
                // keep the scaled product steady while the result waits
                mul_a = pns_pkg::MA_W'(amplitude);
                mul_b = pns_pkg::MB_W'(n_reg);
                done  = out_free;
            end
            default:     ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pns_pkg::S_IDLE;
            last_y_reg <= '0;
            fsel_reg   <= '0;
            pair_reg   <= '0;
            xbit_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                cache_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pns_pkg::S_IDLE && start)
            begin
                fsel_reg <= '0;
                pair_reg <= '0;
                xbit_reg <= 1'b0;
                if (!sample.planar && (sample.column_start || sample.iy != last_y_reg))
                    last_y_reg <= sample.iy;
            end
            if (state_reg == pns_pkg::S_FADE_STORE)
                fsel_reg <= fsel_reg + 2'd1;
            if (state_reg == pns_pkg::S_CORNER_GRAD)
                xbit_reg <= 1'b1;
            if (state_reg == pns_pkg::S_CORNER_LERP)
            begin
                xbit_reg <= 1'b0;
                pair_reg <= pair_reg + pair_step;
                if (!smp_reg.planar)
                    cache_reg[pair_reg] <= g0_reg + ps;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pns_pkg::S_IDLE:
            begin
                if (start)
                begin
                    smp_reg       <= sample;
                    recompute_reg <= sample.column_start || sample.iy != last_y_reg;
                end
            end
            pns_pkg::S_FADE_CUBE:  t2_reg <= p_hi;
            pns_pkg::S_FADE_STORE:
            begin
                unique case (fsel_reg)
                    2'd0:    fx_reg <= f_sel_val;
                    2'd1:    fz_reg <= f_sel_val;
                    default: fy_reg <= f_sel_val;
                endcase
            end
            pns_pkg::S_HASH_X1:    ha_reg <= rd_data + iy_hash;
            pns_pkg::S_HASH_A0:    hb_reg <= rd_data + iy_hash;
            pns_pkg::S_HASH_A1:    aa_reg <= rd_data + smp_reg.iz;
            pns_pkg::S_HASH_B0:    ab_reg <= rd_data + smp_reg.iz;
            pns_pkg::S_HASH_B1:    ba_reg <= rd_data + smp_reg.iz;
            pns_pkg::S_HASH_LAST:  bb_reg <= rd_data + smp_reg.iz;
            pns_pkg::S_CORNER_GRAD:
            begin
                if (!xbit_reg)
                    g0_reg <= g_cur;
            end
            pns_pkg::S_CORNER_LERP: lx_reg[pair_reg] <= g0_reg + ps;
            pns_pkg::S_Y0_ADD:     y1_reg <= cache_reg[0] + ps;
            pns_pkg::S_Y1_ADD:     y2_reg <= cache_reg[2] + ps;
            pns_pkg::S_Z_ADD:      n_reg  <= z_a + ps;
            default:      ;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/perlin_noise_sampler.sv
// ----------------------------------------------------------------------------
// perlin_noise_sampler
// Improved Perlin noise in Q15.16 over a software-loaded permutation table.
// ----------------------------------------------------------------------------
// A table-write item goes straight into the table. A 3D sample that reuses
// the cached corner values finishes soonest, a planar sample takes longer,
// and a 3D sample that recomputes its corners (first y of a column or a new
// y cell) takes longest. These times are set by the single shared multiplier,
// which carries every fade, lerp and the amplitude scaling, and by the one
// read port of the permutation table, which serves the hash chain one entry
// per cycle. in_ready is high only while no sample is in progress; a finished
// result sits in an output register until taken. Load all 256 table entries
// before the first sample.
`default_nettype none

module perlin_noise_sampler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               operation,
    input  wire logic [7:0]                         table_index,
    input  wire logic [7:0]                         table_value,
    input  wire logic signed [31:0]                 pos_x,
    input  wire logic signed [31:0]                 pos_y,
    input  wire logic signed [31:0]                 pos_z,
    input  wire logic                               planar,
    input  wire logic                               column_start,
    input  wire logic signed [31:0]                 accumulate_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [31:0]                      noise_out,
    input  wire logic                               cfg_we,
    input  wire logic [pns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pns_pkg::CFG_W-1:0]          cfg_data
);

    localparam int F = pns_pkg::FRAC_BITS;

    logic [pns_pkg::OFS_W-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [pns_pkg::AMP_W-1:0] amplitude_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        noise_reg;

    logic                      accept;
    logic                      core_idle, core_done, out_free, start, tbl_we;
    logic signed [31:0]        core_result;
    logic [pns_pkg::CELL_W-1:0] rd_addr, rd_data;
    logic signed [pns_pkg::EXT_W-1:0] sx, sy, sz;
    pns_pkg::sample_t          sample;

    assign in_ready  = core_idle;
    assign accept    = in_valid && in_ready;
    assign start     = accept && (operation == pns_pkg::OP_SAMPLE);
    assign tbl_we    = accept && (operation == pns_pkg::OP_TABLE_WRITE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign noise_out = noise_reg;

    // position plus offset, split into cell and fraction
    always_comb
    begin
        sx = pns_pkg::EXT_W'(pos_x) + $signed(pns_pkg::EXT_W'(offset_x_reg));
        sy = pns_pkg::EXT_W'(pos_y) + $signed(pns_pkg::EXT_W'(offset_y_reg));
        sz = pns_pkg::EXT_W'(pos_z) + $signed(pns_pkg::EXT_W'(offset_z_reg));
        sample.ix           = sx[F+pns_pkg::CELL_W-1:F];
        sample.iy           = sy[F+pns_pkg::CELL_W-1:F];
        sample.iz           = sz[F+pns_pkg::CELL_W-1:F];
        sample.dx           = sx[F-1:0];
        sample.dy           = sy[F-1:0];
        sample.dz           = sz[F-1:0];
        sample.planar       = planar;
        sample.column_start = column_start;
        sample.acc          = accumulate_in;
    end

    pns_perm_ram u_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (table_index),
        .wdata (table_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pns_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sample    (sample),
        .amplitude (amplitude_reg),
        .out_free  (out_free),
        .rd_data   (rd_data),
        .rd_addr   (rd_addr),
        .idle      (core_idle),
        .done      (core_done),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            offset_z_reg  <= '0;
            amplitude_reg <= pns_pkg::AMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pns_pkg::CFG_OFFSET_X:  offset_x_reg  <= cfg_data[pns_pkg::OFS_W-1:0];
                    pns_pkg::CFG_OFFSET_Y:  offset_y_reg  <= cfg_data[pns_pkg::OFS_W-1:0];
                    pns_pkg::CFG_OFFSET_Z:  offset_z_reg  <= cfg_data[pns_pkg::OFS_W-1:0];
                    pns_pkg::CFG_AMPLITUDE: amplitude_reg <= cfg_data[pns_pkg::AMP_W-1:0];
                    default:                ;
                endcase
            end
            if (core_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
            noise_reg <= core_result;
    end

endmodule

`default_nettype wire
